@@ src/rectangle_update_min_prefix_search_core_defines.svh @@
// Assertion macros used by the checker file.
`ifndef RECTANGLE_UPDATE_MIN_PREFIX_SEARCH_CORE_DEFINES_SVH
`define RECTANGLE_UPDATE_MIN_PREFIX_SEARCH_CORE_DEFINES_SVH

// Consequent must hold in the cycle after the antecedent.
`define RUMPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rumps: next-cycle check failed");

// Consequent must hold in the same cycle as the antecedent.
`define RUMPS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rumps: same-cycle check failed");

`endif

@@ src/rumps_pkg.sv @@
// ----------------------------------------------------------------------------
// rumps_pkg
// Shared sizes, types and codes of the rectangle update prefix search core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rumps_pkg;

  localparam int MAX_ROWS    = 1024;
  localparam int MAX_COLS    = 1024;
  localparam int MAX_UPDATES = 65536;

  localparam int DIM_W      = 11;
  localparam int CRN_W      = DIM_W + 1;
  localparam int AMT_W      = 32;
  localparam int SUM_W      = 64;
  localparam int CFG_W      = 32;
  localparam int ROW_AW     = $clog2(MAX_ROWS);
  localparam int COL_AW     = $clog2(MAX_COLS);
  localparam int CELL_AW    = ROW_AW + COL_AW;
  localparam int CELL_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int UPD_AW     = $clog2(MAX_UPDATES);
  localparam int CNT_W      = $clog2(MAX_UPDATES + 1);
  localparam int SRCH_W     = CNT_W + 1;

  localparam logic OP_CELL = 1'b0;
  localparam logic OP_RECT = 1'b1;

  typedef enum logic [1:0] {
    CFG_ROWS = 2'd0,
    CFG_COLS = 2'd1,
    CFG_THR  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic        [DIM_W-1:0] r1;
    logic        [DIM_W-1:0] c1;
    logic        [DIM_W-1:0] r2;
    logic        [DIM_W-1:0] c2;
    logic signed [AMT_W-1:0] amt;
  } upd_t;

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b000_0000_0001,
    ST_CLEAR  = 11'b000_0000_0010,
    ST_PICK   = 11'b000_0000_0100,
    ST_APPLY  = 11'b000_0000_1000,
    ST_UWAIT  = 11'b000_0001_0000,
    ST_CRN_RD = 11'b000_0010_0000,
    ST_CRN_WR = 11'b000_0100_0000,
    ST_SWEEP  = 11'b000_1000_0000,
    ST_DRAIN  = 11'b001_0000_0000,
    ST_DECIDE = 11'b010_0000_0000,
    ST_OUTQ   = 11'b100_0000_0000
  } state_t;

endpackage

@@ src/rumps_ram.sv @@
// ----------------------------------------------------------------------------
// rumps_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rumps_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 1024,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  // write, then registered read (old data on collision)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/rumps_cell.sv @@
// ----------------------------------------------------------------------------
// rumps_cell
// Prefix sum step for one cell and its threshold check.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rumps_cell import rumps_pkg::*; (
  input  logic signed [SUM_W-1:0] diff_val,
  input  logic signed [SUM_W-1:0] col_in,
  input  logic signed [SUM_W-1:0] row_in,
  input  logic signed [AMT_W-1:0] base_val,
  input  logic signed [AMT_W-1:0] thr,
  output logic signed [SUM_W-1:0] col_out,
  output logic signed [SUM_W-1:0] row_out,
  output logic                    low
);

  logic signed [SUM_W-1:0] total;

  // column running sum, then row running sum over columns
  assign col_out = col_in + diff_val;
  assign row_out = row_in + col_out;
  assign total   = row_out + SUM_W'(base_val);
  assign low     = total < SUM_W'(thr);

endmodule

@@ src/rectangle_update_min_prefix_search_core.sv @@
// ----------------------------------------------------------------------------
// rectangle_update_min_prefix_search_core
// Loads base cells and rectangle updates, then binary-searches the smallest
// update count that lifts every cell in use to the threshold.
//
// Usage:
//   Input requests (in_valid/in_ready) carry either a base cell (op 0) or a
//   rectangle update (op 1). Loads are taken back to back while idle. A
//   request with in_last set starts the search once it is stored; in_ready
//   stays low until the search result is placed in the output register.
//   The result leaves on out_valid/out_ready. The output register holds it
//   while the receiver stalls; new loads are taken meanwhile, and a later
//   search waits before handing over its result.
//   A search runs about log2(count) trials. One trial places the corners of
//   the first mid updates (up to four read-modify-writes on the difference
//   RAM per update), then sweeps the prefix sums over rows * cols cells (one
//   cell per cycle through the difference RAM).
//   The sweep writes zeros back, so the difference RAM is clean for the
//   next trial.
//   After reset the difference RAM is cleared, one entry per cycle, over all
//   MAX_ROWS * MAX_COLS = 1048576 entries; in_ready stays low during that
//   pass. Configuration writes are taken at any time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rectangle_update_min_prefix_search_core import rumps_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  logic [CFG_W-1:0]        cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_op,
  input  logic [DIM_W-1:0]        in_row_a,
  input  logic [DIM_W-1:0]        in_col_a,
  input  logic [DIM_W-1:0]        in_row_b,
  input  logic [DIM_W-1:0]        in_col_b,
  input  logic signed [AMT_W-1:0] in_amount,
  input  logic                    in_last,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [CNT_W-1:0]        out_answer
);

  // configuration
  logic [DIM_W-1:0]        rows_r, cols_r;
  logic signed [AMT_W-1:0] thr_r;
  logic [DIM_W-1:0]        n_sat, m_sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= DIM_W'(MAX_ROWS);
      cols_r <= DIM_W'(MAX_COLS);
      thr_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ROWS: rows_r <= cfg_wdata[DIM_W-1:0];
        CFG_COLS: cols_r <= cfg_wdata[DIM_W-1:0];
        CFG_THR:  thr_r  <= cfg_wdata[AMT_W-1:0];
        default: ;
      endcase
    end
  end

  assign n_sat = (rows_r > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : rows_r;
  assign m_sat = (cols_r > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : cols_r;

  // control state
  state_t                  state_r, state_nxt;
  logic [CELL_AW-1:0]      clr_r, clr_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [SRCH_W-1:0]       lo_r, lo_nxt, hi_r, hi_nxt;
  logic [CNT_W-1:0]        ans_r, ans_nxt, mid_r, mid_nxt;
  logic [CNT_W-1:0]        ai_r, ai_nxt;
  logic [1:0]              k_r, k_nxt;
  upd_t                    upd_r, upd_nxt;
  logic [CELL_AW-1:0]      caddr_r, caddr_nxt;
  logic signed [SUM_W-1:0] delta_r, delta_nxt;
  logic [DIM_W-1:0]        sr_r, sr_nxt, sc_r, sc_nxt;
  logic                    s1_valid_r;
  logic [DIM_W-1:0]        s1_r_r, s1_c_r;
  logic signed [SUM_W-1:0] rowrun_r, rowrun_nxt;
  logic                    fail_r, fail_nxt;
  logic                    vfw_valid_r;
  logic signed [SUM_W-1:0] vfw_data_r;
  logic                    out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]        out_answer_r, out_answer_nxt;

  // memory ports
  logic                    d_we;
  logic [CELL_AW-1:0]      d_wa, d_ra;
  logic signed [SUM_W-1:0] d_wd, d_rd;
  logic                    b_we;
  logic [CELL_AW-1:0]      b_wa;
  logic signed [AMT_W-1:0] b_rd;
  logic                    u_we;
  upd_t                    u_wd, u_rd;
  logic                    v_we;
  logic [COL_AW-1:0]       v_wa, v_ra;
  logic signed [SUM_W-1:0] v_wd, v_rd;

  rumps_ram #(.W(SUM_W), .DEPTH(CELL_DEPTH)) u_diff (
    .clk(clk), .we(d_we), .waddr(d_wa), .wdata(d_wd), .raddr(d_ra), .rdata(d_rd)
  );

  rumps_ram #(.W(AMT_W), .DEPTH(CELL_DEPTH)) u_base (
    .clk(clk), .we(b_we), .waddr(b_wa), .wdata(in_amount), .raddr(d_ra), .rdata(b_rd)
  );

  rumps_ram #(.W($bits(upd_t)), .DEPTH(MAX_UPDATES)) u_upd (
    .clk(clk), .we(u_we), .waddr(cnt_r[UPD_AW-1:0]), .wdata(u_wd),
    .raddr(ai_r[UPD_AW-1:0]), .rdata(u_rd)
  );

  rumps_ram #(.W(SUM_W), .DEPTH(MAX_COLS)) u_col (
    .clk(clk), .we(v_we), .waddr(v_wa), .wdata(v_wd), .raddr(v_ra), .rdata(v_rd)
  );

  // input handshake
  logic in_acc;
  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;

  logic [DIM_W-1:0] ra_m1, ca_m1;
  assign ra_m1 = in_row_a - 1'b1;
  assign ca_m1 = in_col_a - 1'b1;
  assign b_we  = in_acc && (in_op == OP_CELL) && (in_row_a != '0) && (in_col_a != '0)
                 && (in_row_a <= DIM_W'(MAX_ROWS)) && (in_col_a <= DIM_W'(MAX_COLS));
  assign b_wa  = {ra_m1[ROW_AW-1:0], ca_m1[COL_AW-1:0]};
  assign u_we  = in_acc && (in_op == OP_RECT) && (cnt_r < CNT_W'(MAX_UPDATES));
  always_comb begin
    u_wd.r1  = (in_row_a == '0) ? DIM_W'(1) : in_row_a;
    u_wd.c1  = (in_col_a == '0) ? DIM_W'(1) : in_col_a;
    u_wd.r2  = in_row_b;
    u_wd.c2  = in_col_b;
    u_wd.amt = in_amount;
  end

  // corner selection for the current update
  logic [CRN_W-1:0]        cr, cc, cr_m1, cc_m1;
  logic                    cneg, crn_ok;
  logic [CELL_AW-1:0]      crn_addr;
  logic signed [SUM_W-1:0] amt64;

  always_comb begin
    case (k_r)
      2'd0: begin cr = {1'b0, upd_r.r1}; cc = {1'b0, upd_r.c1}; cneg = 1'b0; end
      2'd1: begin cr = {1'b0, upd_r.r2} + 1'b1; cc = {1'b0, upd_r.c2} + 1'b1; cneg = 1'b0; end
      2'd2: begin cr = {1'b0, upd_r.r1}; cc = {1'b0, upd_r.c2} + 1'b1; cneg = 1'b1; end
      default: begin cr = {1'b0, upd_r.r2} + 1'b1; cc = {1'b0, upd_r.c1}; cneg = 1'b1; end
    endcase
  end

  assign cr_m1    = cr - 1'b1;
  assign cc_m1    = cc - 1'b1;
  assign crn_ok   = (cr != '0) && (cc != '0) && (cr <= {1'b0, n_sat}) && (cc <= {1'b0, m_sat});
  assign crn_addr = {cr_m1[ROW_AW-1:0], cc_m1[COL_AW-1:0]};
  assign amt64    = SUM_W'(upd_r.amt);

  // sweep addressing and cell step
  logic [DIM_W-1:0]        sr_m1, sc_m1, s1r_m1, s1c_m1;
  logic [CELL_AW-1:0]      sw_addr, s1_addr;
  logic signed [SUM_W-1:0] col_in, row_in, col_out, row_out;
  logic                    cell_low;

  assign sr_m1   = sr_r - 1'b1;
  assign sc_m1   = sc_r - 1'b1;
  assign s1r_m1  = s1_r_r - 1'b1;
  assign s1c_m1  = s1_c_r - 1'b1;
  assign sw_addr = {sr_m1[ROW_AW-1:0], sc_m1[COL_AW-1:0]};
  assign s1_addr = {s1r_m1[ROW_AW-1:0], s1c_m1[COL_AW-1:0]};
  assign col_in  = (s1_r_r == DIM_W'(1)) ? '0 : (vfw_valid_r ? vfw_data_r : v_rd);
  assign row_in  = (s1_c_r == DIM_W'(1)) ? '0 : rowrun_r;

  rumps_cell u_cell (
    .diff_val(d_rd), .col_in(col_in), .row_in(row_in), .base_val(b_rd), .thr(thr_r),
    .col_out(col_out), .row_out(row_out), .low(cell_low)
  );

  assign v_ra = sc_m1[COL_AW-1:0];
  assign v_we = s1_valid_r;
  assign v_wa = s1c_m1[COL_AW-1:0];
  assign v_wd = col_out;

  // difference RAM port steering
  always_comb begin
    d_we = 1'b0;
    d_wa = '0;
    d_wd = '0;
    d_ra = sw_addr;
    if (state_r == ST_CLEAR) begin
      d_we = 1'b1;
      d_wa = clr_r;
    end else if (state_r == ST_CRN_RD) begin
      d_ra = crn_addr;
    end else if (state_r == ST_CRN_WR) begin
      d_we = 1'b1;
      d_wa = caddr_r;
      d_wd = d_rd + delta_r;
    end else if (s1_valid_r) begin
      d_we = 1'b1;
      d_wa = s1_addr;
    end
  end

  // sequencer
  logic [SRCH_W:0] lohi;
  assign lohi = {1'b0, lo_r} + {1'b0, hi_r};

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    cnt_nxt        = cnt_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    ans_nxt        = ans_r;
    mid_nxt        = mid_r;
    ai_nxt         = ai_r;
    k_nxt          = k_r;
    upd_nxt        = upd_r;
    caddr_nxt      = caddr_r;
    delta_nxt      = delta_r;
    sr_nxt         = sr_r;
    sc_nxt         = sc_r;
    rowrun_nxt     = s1_valid_r ? row_out : rowrun_r;
    fail_nxt       = fail_r | (s1_valid_r & cell_low);
    out_valid_nxt  = out_valid_r && !out_ready;
    out_answer_nxt = out_answer_r;
    case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == CELL_AW'(CELL_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          cnt_nxt = u_we ? cnt_r + 1'b1 : cnt_r;
          if (in_last) begin
            lo_nxt    = SRCH_W'(1);
            hi_nxt    = {1'b0, cnt_nxt};
            ans_nxt   = '0;
            state_nxt = ST_PICK;
          end
        end
      end
      ST_PICK: begin
        if (lo_r > hi_r) begin
          state_nxt = ST_OUTQ;
        end else begin
          mid_nxt   = lohi[CNT_W:1];
          ai_nxt    = '0;
          state_nxt = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (ai_r == mid_r) begin
          sr_nxt    = DIM_W'(1);
          sc_nxt    = DIM_W'(1);
          fail_nxt  = 1'b0;
          state_nxt = (n_sat == '0 || m_sat == '0) ? ST_DECIDE : ST_SWEEP;
        end else begin
          state_nxt = ST_UWAIT;
        end
      end
      ST_UWAIT: begin
        upd_nxt   = u_rd;
        k_nxt     = '0;
        state_nxt = ST_CRN_RD;
      end
      ST_CRN_RD: begin
        caddr_nxt = crn_addr;
        delta_nxt = cneg ? -amt64 : amt64;
        if (crn_ok) begin
          state_nxt = ST_CRN_WR;
        end else begin
          k_nxt = k_r + 1'b1;
          if (k_r == 2'd3) begin
            ai_nxt    = ai_r + 1'b1;
            state_nxt = ST_APPLY;
          end
        end
      end
      ST_CRN_WR: begin
        k_nxt = k_r + 1'b1;
        if (k_r == 2'd3) begin
          ai_nxt    = ai_r + 1'b1;
          state_nxt = ST_APPLY;
        end else begin
          state_nxt = ST_CRN_RD;
        end
      end
      ST_SWEEP: begin
        if (sc_r == m_sat) begin
          sc_nxt = DIM_W'(1);
          if (sr_r == n_sat) begin
            state_nxt = ST_DRAIN;
          end else begin
            sr_nxt = sr_r + 1'b1;
          end
        end else begin
          sc_nxt = sc_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (!fail_r) begin
          ans_nxt = mid_r;
          hi_nxt  = {1'b0, mid_r} - 1'b1;
        end else begin
          lo_nxt  = {1'b0, mid_r} + 1'b1;
        end
        state_nxt = ST_PICK;
      end
      ST_OUTQ: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_answer_nxt = ans_r;
          cnt_nxt        = '0;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      cnt_r       <= '0;
      s1_valid_r  <= 1'b0;
      vfw_valid_r <= 1'b0;
      fail_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cnt_r       <= cnt_nxt;
      s1_valid_r  <= (state_r == ST_SWEEP);
      vfw_valid_r <= v_we && (v_wa == v_ra);
      fail_r      <= fail_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    ans_r        <= ans_nxt;
    mid_r        <= mid_nxt;
    ai_r         <= ai_nxt;
    k_r          <= k_nxt;
    upd_r        <= upd_nxt;
    caddr_r      <= caddr_nxt;
    delta_r      <= delta_nxt;
    sr_r         <= sr_nxt;
    sc_r         <= sc_nxt;
    s1_r_r       <= sr_r;
    s1_c_r       <= sc_r;
    rowrun_r     <= rowrun_nxt;
    vfw_data_r   <= v_wd;
    out_answer_r <= out_answer_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_answer = out_answer_r;

endmodule

@@ src/rumps_checker.sv @@
// ----------------------------------------------------------------------------
// rumps_checker
// Port-level checks of the search core, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rectangle_update_min_prefix_search_core_defines.svh"

module rumps_checker import rumps_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             in_last,
  input logic             out_valid,
  input logic             out_ready,
  input logic [CNT_W-1:0] out_answer
);

  // hold a stalled result
  `RUMPS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_answer))

  // a search blocks the input in the cycle after its last request is taken
  `RUMPS_ASSERT_NEXT(a_last_blocks, clk, rst_n, in_valid && in_ready && in_last, !in_ready)

  // answer never exceeds MAX_UPDATES
  `RUMPS_ASSERT_NOW(a_ans_range, clk, rst_n, out_valid, out_answer <= CNT_W'(MAX_UPDATES))

  // a result only appears after a search left the input blocked
  `RUMPS_ASSERT_NOW(a_out_cause, clk, rst_n, out_valid && !$past(out_valid), $past(!in_ready))

endmodule

bind rectangle_update_min_prefix_search_core rumps_checker u_rumps_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready), .in_last(in_last),
  .out_valid(out_valid), .out_ready(out_ready), .out_answer(out_answer)
);

@@ test/rectangle_update_min_prefix_search_core_tb.sv @@
// ----------------------------------------------------------------------------
// rectangle_update_min_prefix_search_core_tb
// Loads base cells and rectangle updates through the request channel under
// random gaps and stalls, and predicts each search answer with an in-bench
// prefix-sum search over the cells in use. Grid sizes and the threshold move
// between phases, including size extremes and saturated sizes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rectangle_update_min_prefix_search_core_tb;
  import rumps_pkg::*;

  typedef struct {
    logic                    op;
    logic [DIM_W-1:0]        ra;
    logic [DIM_W-1:0]        ca;
    logic [DIM_W-1:0]        rb;
    logic [DIM_W-1:0]        cb;
    logic signed [AMT_W-1:0] amt;
    logic                    last;
  } load_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  cfg_idx_t cfg_index = CFG_ROWS;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_op = OP_CELL;
  logic [DIM_W-1:0] in_row_a = '0, in_col_a = '0, in_row_b = '0, in_col_b = '0;
  logic signed [AMT_W-1:0] in_amount = '0;
  logic in_last = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [CNT_W-1:0] out_answer;

  rectangle_update_min_prefix_search_core dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stimulus side
  load_t pending_loads[$];
  bit    cell_loaded[int];
  bit    calm = 1'b0;
  int    in_gap = 0;
  bit    in_taken = 1'b0;

  // Predictor state
  logic signed [AMT_W-1:0] base_cells[int];
  load_t                   rect_list[$];
  logic [DIM_W-1:0]        rows_cfg = 11'd1024;
  logic [DIM_W-1:0]        cols_cfg = 11'd1024;
  logic signed [AMT_W-1:0] thr_cfg = '0;
  logic [CNT_W-1:0]        answers_due[$];

  int  out_stall = 0;
  bit  failed = 1'b0;

  // Apply the first count rectangles and check every cell in use.
  function automatic bit lifts_all(int count);
    int n, m, r, c, r1, c1, r2, c2, w;
    longint d[];
    longint v, s;
    n = (rows_cfg > MAX_ROWS) ? MAX_ROWS : rows_cfg;
    m = (cols_cfg > MAX_COLS) ? MAX_COLS : cols_cfg;
    w = m + 1;
    d = new[(n + 1) * w];
    foreach (d[i]) d[i] = 0;
    for (int i = 0; i < count; i++) begin
      r1 = (rect_list[i].ra == 0) ? 1 : rect_list[i].ra;
      c1 = (rect_list[i].ca == 0) ? 1 : rect_list[i].ca;
      r2 = rect_list[i].rb + 1;
      c2 = rect_list[i].cb + 1;
      v  = rect_list[i].amt;
      // drop corners that land outside the checked region
      if (r1 <= n && c1 <= m) d[r1 * w + c1] += v;
      if (r2 <= n && c2 <= m) d[r2 * w + c2] += v;
      if (r1 <= n && c2 <= m) d[r1 * w + c2] -= v;
      if (r2 <= n && c1 <= m) d[r2 * w + c1] -= v;
    end
    for (r = 1; r <= n; r++)
      for (c = 1; c <= m; c++) begin
        s = d[r * w + c] + d[r * w + c - 1] + d[(r - 1) * w + c] - d[(r - 1) * w + c - 1];
        d[r * w + c] = s;
        if (s + longint'(base_cells[(r - 1) * MAX_COLS + (c - 1)]) < longint'(thr_cfg))
          return 1'b0;
      end
    return 1'b1;
  endfunction

  function automatic int min_passing_count();
    int lo, hi, mid, best;
    lo = 1;
    hi = rect_list.size();
    best = 0;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (lifts_all(mid)) begin
        best = mid;
        hi = mid - 1;
      end else begin
        lo = mid + 1;
      end
    end
    return best;
  endfunction

  function automatic void absorb_request(load_t it);
    if (it.op == OP_CELL) begin
      if (it.ra >= 1 && it.ra <= MAX_ROWS && it.ca >= 1 && it.ca <= MAX_COLS)
        base_cells[(it.ra - 1) * MAX_COLS + (it.ca - 1)] = it.amt;
    end else if (rect_list.size() < MAX_UPDATES) begin
      rect_list.push_back(it);
    end
    if (it.last) begin
      answers_due.push_back(CNT_W'(min_passing_count()));
      rect_list.delete();
    end
  endfunction

  // Take requests and results at the rising edge
  always @(posedge clk) begin
    load_t it;
    if (rst_n && in_valid && in_ready) begin
      it = '{in_op, in_row_a, in_col_a, in_row_b, in_col_b, in_amount, in_last};
      absorb_request(it);
      in_taken <= 1'b1;
    end
    if (rst_n && out_valid && out_ready) begin
      if (answers_due.size() == 0) begin
        $display("%0t: unexpected answer: expected none, actual %0d", $time, out_answer);
        failed = 1'b1;
      end else begin
        if (out_answer !== answers_due[0]) begin
          $display("%0t: answer mismatch: expected %0d, actual %0d",
                   $time, answers_due[0], out_answer);
          failed = 1'b1;
        end
        void'(answers_due.pop_front());
      end
      out_stall <= calm ? 0 : $urandom_range(0, 11);
    end
  end

  // Drive requests at the falling edge
  always @(negedge clk) begin
    load_t it;
    if (rst_n && (!in_valid || in_taken)) begin
      in_taken <= 1'b0;
      if (in_gap > 0) begin
        in_gap   <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_loads.size() > 0) begin
        it = pending_loads.pop_front();
        in_op     <= it.op;
        in_row_a  <= it.ra;
        in_col_a  <= it.ca;
        in_row_b  <= it.rb;
        in_col_b  <= it.cb;
        in_amount <= it.amt;
        in_last   <= it.last;
        in_valid  <= 1'b1;
        in_gap    <= calm ? 0 : $urandom_range(0, 11);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Stall the result side at the falling edge
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_stall > 0) begin
        out_stall <= out_stall - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic push_load(logic op, int ra, int ca, int rb, int cb,
                           logic signed [AMT_W-1:0] amt, logic last);
    load_t it;
    it = '{op, DIM_W'(ra), DIM_W'(ca), DIM_W'(rb), DIM_W'(cb), amt, last};
    if (op == OP_CELL && ra >= 1 && ra <= MAX_ROWS && ca >= 1 && ca <= MAX_COLS)
      cell_loaded[(ra - 1) * MAX_COLS + (ca - 1)] = 1'b1;
    pending_loads.push_back(it);
  endtask

  function automatic logic signed [AMT_W-1:0] rand_amount();
    if ($urandom_range(0, 7) == 0) return $urandom;
    return $signed($urandom_range(0, 100)) - 50;
  endfunction

  // Wait until the block has drained
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_loads.size() != 0 || in_valid || answers_due.size() != 0);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_ROWS: rows_cfg = val[DIM_W-1:0];
      CFG_COLS: cols_cfg = val[DIM_W-1:0];
      default:  thr_cfg  = val;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_grid(int rows, int cols, logic signed [AMT_W-1:0] thr);
    wait_idle();
    calm = ($urandom_range(0, 3) == 0);
    write_reg(CFG_ROWS, rows);
    write_reg(CFG_COLS, cols);
    write_reg(CFG_THR, thr);
  endtask

  // Load every cell of the region that has never been written
  task automatic fill_region();
    int n, m;
    n = (rows_cfg > MAX_ROWS) ? MAX_ROWS : rows_cfg;
    m = (cols_cfg > MAX_COLS) ? MAX_COLS : cols_cfg;
    for (int r = 1; r <= n; r++)
      for (int c = 1; c <= m; c++)
        if (!cell_loaded.exists((r - 1) * MAX_COLS + (c - 1)))
          push_load(OP_CELL, r, c, $urandom, $urandom, rand_amount(), 1'b0);
  endtask

  // One search: a few cell rewrites, then updates ending in last
  task automatic search_batch();
    int n, m, k, ra, ca, rb, cb;
    n = (rows_cfg > MAX_ROWS) ? MAX_ROWS : rows_cfg;
    m = (cols_cfg > MAX_COLS) ? MAX_COLS : cols_cfg;
    if (n < 1) n = 1;
    if (m < 1) m = 1;
    repeat ($urandom_range(0, 2))
      push_load(OP_CELL, $urandom_range(1, n), $urandom_range(1, m),
                $urandom, $urandom, rand_amount(), 1'b0);
    k = $urandom_range(1, 10);
    for (int i = 0; i < k; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        // noise: any field value at all
        ra = $urandom_range(0, 2047); ca = $urandom_range(0, 2047);
        rb = $urandom_range(0, 2047); cb = $urandom_range(0, 2047);
      end else begin
        ra = $urandom_range(0, n + 1); ca = $urandom_range(0, m + 1);
        rb = $urandom_range((ra > 0) ? ra - 1 : 0, n + 1);
        cb = $urandom_range((ca > 0) ? ca - 1 : 0, m + 1);
      end
      push_load(OP_RECT, ra, ca, rb, cb, rand_amount(), i == k - 1);
    end
  endtask

  initial begin
    int n;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: small grid, field extremes and corner cases
    set_grid(2, 3, 0);
    fill_region();
    push_load(OP_CELL, 1, 1, 0, 0, 32'sh8000_0000, 1'b0);
    push_load(OP_CELL, 2, 3, 2047, 2047, 32'sh7fff_ffff, 1'b0);
    push_load(OP_CELL, 0, 2, 0, 0, 5, 1'b0);          // out-of-range rows
    push_load(OP_CELL, 1025, 1, 0, 0, 5, 1'b0);
    push_load(OP_CELL, 2047, 2047, 0, 0, -7, 1'b0);
    push_load(OP_CELL, 1, 2, 0, 0, -3, 1'b1);         // last on a cell, no updates
    push_load(OP_RECT, 0, 0, 2, 3, 32'sh7fff_ffff, 1'b0); // edges at zero
    push_load(OP_RECT, 1, 1, 1024, 1024, 10, 1'b0);   // corners past the store
    push_load(OP_RECT, 2047, 2047, 2047, 2047, -1, 1'b0);
    push_load(OP_RECT, 2, 3, 1, 1, -20, 1'b0);        // inverted rectangle
    push_load(OP_RECT, 1, 1, 2, 3, 32'sh8000_0000, 1'b0);
    push_load(OP_RECT, 1, 1, 2, 3, 32'sh7fff_ffff, 1'b1);
    push_load(OP_CELL, 1, 1, 0, 0, 100, 1'b1);

    // Threshold extremes
    set_grid(2, 3, 32'sh8000_0000);
    search_batch();
    set_grid(2, 3, 32'sh7fff_ffff);
    search_batch();

    // Size extremes: tall single column, then empty regions with saturated sizes
    set_grid(1024, 1, $signed($urandom_range(0, 40)) - 20);
    fill_region();
    search_batch();
    search_batch();
    set_grid(0, 2047, 5);
    search_batch();
    set_grid(2047, 0, 5);
    search_batch();

    // Random phases on small grids; each phase starts with an empty queue
    n = 0;
    while (n < 550) begin
      set_grid($urandom_range(1, 6), $urandom_range(1, 6),
               $signed($urandom_range(0, 120)) - 60);
      fill_region();
      repeat ($urandom_range(2, 5)) search_batch();
      n += pending_loads.size();
    end

    wait_idle();
    if (!failed) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #100ms;
    $display("FAIL");
    $finish;
  end

endmodule
